// File: sv/first_free_grid_slot_search_unit_assert.svh
// Assertion macros used by the verification side of the free slot search unit.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef FIRST_FREE_GRID_SLOT_SEARCH_UNIT_ASSERT_SVH
`define FIRST_FREE_GRID_SLOT_SEARCH_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent
`define FFGS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ffgs: same-cycle check failed");

// Check a consequence in the cycle after its antecedent
`define FFGS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ffgs: next-cycle check failed");

`endif

// File: sv/ffgs_pkg.sv
// Shared types, codes and helper functions of the free slot search unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ffgs_pkg;

    // Number of rectangle cells in the chain
    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Signed coordinate wide enough for every inclusive extent end
    localparam int COORD_W = 20;

    // Commands (beat tuser on the input side)
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // Result status (beat tuser on the output side)
    localparam logic [1:0] STS_FOUND = 2'd0;
    localparam logic [1:0] STS_LIMIT = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_MARGIN  = 3'd0;
    localparam logic [2:0] REG_STEP_X  = 3'd1;
    localparam logic [2:0] REG_STEP_Y  = 3'd2;
    localparam logic [2:0] REG_ROW_END = 3'd3;
    localparam logic [2:0] REG_Y_LIMIT = 3'd4;

    typedef logic signed [COORD_W-1:0] t_coord;

    // One stored rectangle as inclusive extents; live folds in managed and origin test
    typedef struct packed {
        logic   live;
        t_coord x0;
        t_coord x1;
        t_coord y0;
        t_coord y1;
    } t_entry;

    // One candidate position travelling down the chain
    typedef struct packed {
        logic   valid;
        logic   over;
        logic   blocked;
        t_coord x0;
        t_coord x1;
        t_coord y0;
        t_coord y1;
    } t_cand;

    typedef struct packed {
        logic [15:0] margin;
        logic [15:0] step_x;
        logic [15:0] step_y;
        logic [15:0] row_end;
        logic [15:0] y_limit;
    } t_cfg;

    function automatic logic in_range(t_coord lo, t_coord v, t_coord hi);
        return (lo <= v) && (v <= hi);
    endfunction

    // Two spans meet when any end of one lies in the other
    function automatic logic spans_meet(t_coord a0, t_coord a1, t_coord b0, t_coord b1);
        return in_range(b0, a0, b1) || in_range(b0, a1, b1) ||
               in_range(a0, b0, a1) || in_range(a0, b1, a1);
    endfunction

endpackage

// File: sv/ffgs_gen.sv
// Candidate generator: walks grid positions row by row and issues one per cycle.
// Depends on ffgs_pkg.
`timescale 1ns / 1ps

module ffgs_gen import ffgs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_kill,
    input  t_cfg        i_cfg,
    input  logic [15:0] i_new_w,
    input  logic [15:0] i_new_h,
    output t_cand       o_cand
);

    logic        r_gv;
    logic [17:0] r_x;
    logic [16:0] r_y;
    logic [16:0] r_x0;
    logic [15:0] r_gw;
    logic [15:0] r_gh;
    logic [16:0] r_gwnw;
    logic [15:0] r_nw;
    logic [15:0] r_nh;
    t_cand       r_cand;

    logic [15:0] gw;
    logic [15:0] gh;
    logic [16:0] x0;
    logic [18:0] x_reach;
    logic        wrap_hit;
    logic        y_over;

    // Zero steps count as one; center in the cell when the width fits
    always_comb begin
        gw = (i_cfg.step_x == 16'd0) ? 16'd1 : i_cfg.step_x;
        gh = (i_cfg.step_y == 16'd0) ? 16'd1 : i_cfg.step_y;
        if (i_new_w > gw) begin
            x0 = {1'b0, i_cfg.margin};
        end else begin
            x0 = {1'b0, i_cfg.margin} + {2'b00, 15'((gw - i_new_w) >> 1)};
        end
    end

    // Wrap when the next x plus the width passes the right limit
    assign x_reach  = {1'b0, r_x} + {2'b00, r_gwnw};
    assign wrap_hit = x_reach > {3'b000, i_cfg.row_end};
    assign y_over   = r_y > {1'b0, i_cfg.y_limit};

    // Position walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv <= 1'b0;
        end else if (i_kill) begin
            r_gv <= 1'b0;
        end else if (i_start) begin
            r_gv <= 1'b1;
        end else if (r_gv && y_over) begin
            r_gv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x0   <= x0;
            r_x    <= {1'b0, x0};
            r_y    <= {1'b0, i_cfg.margin};
            r_gw   <= gw;
            r_gh   <= gh;
            r_gwnw <= {1'b0, gw} + {1'b0, i_new_w};
            r_nw   <= i_new_w;
            r_nh   <= i_new_h;
        end else if (r_gv) begin
            if (wrap_hit) begin
                r_x <= {1'b0, r_x0};
                r_y <= r_y + {1'b0, r_gh};
            end else begin
                r_x <= r_x + {2'b00, r_gw};
            end
        end
    end

    // Head stage: form inclusive extents of the issued position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.valid <= 1'b0;
        end else begin
            r_cand.valid   <= r_gv && !i_kill;
            r_cand.over    <= y_over;
            r_cand.blocked <= 1'b0;
            r_cand.x0      <= t_coord'({2'b00, r_x});
            r_cand.x1      <= t_coord'({2'b00, r_x}) + t_coord'({4'h0, r_nw}) - t_coord'(1);
            r_cand.y0      <= t_coord'({3'b000, r_y});
            r_cand.y1      <= t_coord'({3'b000, r_y}) + t_coord'({4'h0, r_nh}) - t_coord'(1);
        end
    end

    assign o_cand = r_cand;

endmodule

// File: sv/ffgs_cell.sv
// One cell of the rectangle chain: holds a stored entry and tests a passing candidate.
// Depends on ffgs_pkg.
`timescale 1ns / 1ps

module ffgs_cell import ffgs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_kill,
    input  logic   i_load,
    input  logic   i_used,
    input  t_entry i_entry,
    input  t_cand  i_cand,
    output t_entry o_entry,
    output t_cand  o_cand
);

    t_entry r_entry;
    t_cand  r_cand;
    t_cand  n_cand;
    logic   hit;

    // Shift the entry chain on an add
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_entry;
        end
    end

    // Overlap of the candidate with this cell's rectangle
    assign hit = i_used && r_entry.live &&
                 spans_meet(i_cand.x0, i_cand.x1, r_entry.x0, r_entry.x1) &&
                 spans_meet(i_cand.y0, i_cand.y1, r_entry.y0, r_entry.y1);

    always_comb begin
        n_cand         = i_cand;
        n_cand.blocked = i_cand.blocked || hit;
        n_cand.valid   = i_cand.valid && !i_kill;
    end

    // Hand the candidate to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.valid <= 1'b0;
        end else begin
            r_cand <= n_cand;
        end
    end

    assign o_entry = r_entry;
    assign o_cand  = r_cand;

endmodule

// File: sv/first_free_grid_slot_search_unit.sv
// Top level of the free slot search unit: command decode, configuration, cell chain.
// Depends on ffgs_pkg, ffgs_gen and ffgs_cell.
`timescale 1ns / 1ps
//
// Input stream: one beat per command (tuser = command). Clear and add give no
// result and leave the input ready; an add to a full table gives a
// status-full result. A query walks grid positions; the generator steps to one
// position per cycle, which enters a chain of TABLE_DEPTH cells in the cycle
// after, each cell holding one stored rectangle. A position passes through the
// cell registers in order to the tail, marked blocked if any cell's rectangle
// overlaps it. The first unblocked position (or the first past the y limit)
// ends the search and flushes the chain.
// One command is in work at a time; the input is ready again once the result
// has moved to the output register, even while that register waits on tready.
// Output stream: slot_x, slot_y in tdata, status in tuser; a stalled receiver
// holds the beat. Configuration writes are always ready and take effect at once.
// Reset empties the table and restores register defaults; no clearing pass.
//
module first_free_grid_slot_search_unit import ffgs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Command stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata: rect_x[15:0], rect_y[31:16], rect_w[47:32], rect_h[63:48], managed[64],
    //        new_w[80:65], new_h[96:81], zero fill[103:97]
    input  logic [103:0] i_s_axis_tdata,
    // tuser: command[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    // Result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata: slot_x[15:0], slot_y[31:16]
    output logic [31:0]  o_m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]   o_m_axis_tuser,
    // Configuration write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_count;
    t_cfg             r_cfg;
    logic [15:0]      r_pend_x;
    logic [15:0]      r_pend_y;
    logic [1:0]       r_pend_st;
    logic             r_out_v;
    logic [15:0]      r_out_x;
    logic [15:0]      r_out_y;
    logic [1:0]       r_out_st;

    logic             accept;
    logic [1:0]       cmd;
    logic [15:0]      rect_x;
    logic [15:0]      rect_y;
    logic [15:0]      rect_w;
    logic [15:0]      rect_h;
    logic             managed;
    logic [15:0]      new_w;
    logic [15:0]      new_h;
    logic             full;
    logic             add_load;
    logic             start;
    logic             finish;
    logic             out_free;
    t_entry           new_entry;
    t_cand            tail;

    t_entry           w_entry [TABLE_DEPTH];
    t_cand            w_cand  [TABLE_DEPTH+1];

    // Beat fields
    assign cmd     = i_s_axis_tuser;
    assign rect_x  = i_s_axis_tdata[15:0];
    assign rect_y  = i_s_axis_tdata[31:16];
    assign rect_w  = i_s_axis_tdata[47:32];
    assign rect_h  = i_s_axis_tdata[63:48];
    assign managed = i_s_axis_tdata[64];
    assign new_w   = i_s_axis_tdata[80:65];
    assign new_h   = i_s_axis_tdata[96:81];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign full            = (r_count == CNT_W'(TABLE_DEPTH));
    assign add_load        = accept && (cmd == CMD_ADD) && !full;
    assign start           = accept && (cmd == CMD_QUERY);
    assign out_free        = !r_out_v || i_m_axis_tready;

    // Build the inclusive extents of a rectangle being added
    always_comb begin
        new_entry.live = managed && !((rect_x == 16'd0) && (rect_y == 16'd0));
        new_entry.x0   = t_coord'({4'h0, rect_x});
        new_entry.x1   = t_coord'({4'h0, rect_x}) + t_coord'({4'h0, rect_w}) - t_coord'(1);
        new_entry.y0   = t_coord'({4'h0, rect_y});
        new_entry.y1   = t_coord'({4'h0, rect_y}) + t_coord'({4'h0, rect_h}) - t_coord'(1);
    end

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.margin  <= 16'd4;
            r_cfg.step_x  <= 16'd64;
            r_cfg.step_y  <= 16'd64;
            r_cfg.row_end <= 16'd640;
            r_cfg.y_limit <= 16'hFFFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_MARGIN:  r_cfg.margin  <= i_cfg_data;
                REG_STEP_X:  r_cfg.step_x  <= i_cfg_data;
                REG_STEP_Y:  r_cfg.step_y  <= i_cfg_data;
                REG_ROW_END: r_cfg.row_end <= i_cfg_data;
                REG_Y_LIMIT: r_cfg.y_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Candidate generator
    ffgs_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kill  (finish),
        .i_cfg   (r_cfg),
        .i_new_w (new_w),
        .i_new_h (new_h),
        .o_cand  (w_cand[0])
    );

    // Chain of rectangle cells; newest entry enters at cell 0
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        t_entry cell_in;
        logic   used;

        if (i == 0) begin : g_head
            assign cell_in = new_entry;
        end else begin : g_link
            assign cell_in = w_entry[i-1];
        end

        assign used = r_count > CNT_W'(i);

        ffgs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_kill  (finish),
            .i_load  (add_load),
            .i_used  (used),
            .i_entry (cell_in),
            .i_cand  (w_cand[i]),
            .o_entry (w_entry[i]),
            .o_cand  (w_cand[i+1])
        );
    end

    // End of chain: first position past the limit or free ends the search
    assign tail   = w_cand[TABLE_DEPTH];
    assign finish = (r_state == ST_SEARCH) && tail.valid && (tail.over || !tail.blocked);

    // Command sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (cmd)
                            CMD_CLEAR: r_count <= '0;
                            CMD_ADD: begin
                                if (full) begin
                                    r_state <= ST_WAIT;
                                end else begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            CMD_QUERY: r_state <= ST_SEARCH;
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SEARCH: begin
                    if (finish) begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Pending result: hold until the output register frees up
    always_ff @(posedge i_clk) begin
        if (accept && (cmd == CMD_ADD) && full) begin
            r_pend_x  <= 16'd0;
            r_pend_y  <= 16'd0;
            r_pend_st <= STS_FULL;
        end else if (finish) begin
            if (tail.over) begin
                r_pend_x  <= 16'd0;
                r_pend_y  <= 16'd0;
                r_pend_st <= STS_LIMIT;
            end else begin
                r_pend_x  <= (tail.x0[COORD_W-1:16] != '0) ? 16'hFFFF : tail.x0[15:0];
                r_pend_y  <= tail.y0[15:0];
                r_pend_st <= STS_FOUND;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if ((r_state == ST_WAIT) && out_free) begin
            r_out_v <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_WAIT) && out_free) begin
            r_out_x  <= r_pend_x;
            r_out_y  <= r_pend_y;
            r_out_st <= r_pend_st;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {r_out_y, r_out_x};
    assign o_m_axis_tuser  = r_out_st;

endmodule

// File: sv/ffgs_checker.sv
// Port-level checker of the free slot search unit, bound to the top level.
// Depends on ffgs_pkg and first_free_grid_slot_search_unit_assert.svh.
`timescale 1ns / 1ps
`include "first_free_grid_slot_search_unit_assert.svh"

module ffgs_checker import ffgs_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [1:0]   i_s_axis_tuser,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [31:0]  o_m_axis_tdata,
    input logic [1:0]   o_m_axis_tuser
);

    // A stalled result beat holds
    `FFGS_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // Limit and full results carry no position
    `FFGS_ASSERT_NOW(a_no_pos, o_m_axis_tvalid && (o_m_axis_tuser != STS_FOUND), o_m_axis_tdata == 32'd0)

    // An accepted query closes the input
    `FFGS_ASSERT_NEXT(a_query_busy, i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == CMD_QUERY), !o_s_axis_tready)

    // The input closes only right after a beat was taken
    `FFGS_ASSERT_NOW(a_busy_cause, $fell(o_s_axis_tready), $past(i_s_axis_tvalid))

endmodule

bind first_free_grid_slot_search_unit ffgs_checker u_ffgs_checker (.*);

// File: dv/tb_top.sv
// Testbench for the first free grid slot search unit: directed and random command streams.
// Depends on ffgs_pkg and first_free_grid_slot_search_unit; results checked against a local model.
`timescale 1ns / 1ps

module tb_top;
    import ffgs_pkg::*;

    // Search steps allowed for a random query before it is swapped for a clear
    localparam int STEP_CAP    = 400;
    localparam int SETTLE_CYC  = TABLE_DEPTH + 8;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 150;

    typedef struct packed {
        logic [15:0] slot_x;
        logic [15:0] slot_y;
        logic [1:0]  status;
    } slot_result_t;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        bit          managed;
    } placed_rect_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [103:0] i_s_axis_tdata;
    logic [1:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [31:0]  o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [15:0]  i_cfg_data;

    // Local copy of the table and the grid settings
    placed_rect_t placed [TABLE_DEPTH];
    int           placed_count;
    logic [15:0]  grid_margin;
    logic [15:0]  grid_step_x;
    logic [15:0]  grid_step_y;
    logic [15:0]  row_wrap;
    logic [15:0]  row_y_limit;

    slot_result_t pending_slots [$];
    int           mismatches;
    bit           bubbles_on;
    bit           backpressure_on;

    first_free_grid_slot_search_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------- model

    function automatic bit spans_cross(longint a0, longint a1, longint b0, longint b1);
        return (b0 <= a0 && a0 <= b1) || (b0 <= a1 && a1 <= b1) ||
               (a0 <= b0 && b0 <= a1) || (a0 <= b1 && b1 <= a1);
    endfunction

    // Any managed entry off the origin that meets the candidate extent
    function automatic bit rect_blocks(longint px, longint py, longint pw, longint ph);
        longint ex, ey, ew, eh;
        for (int i = 0; i < placed_count; i++) begin
            ex = placed[i].x;
            ey = placed[i].y;
            ew = placed[i].w;
            eh = placed[i].h;
            if (!placed[i].managed || (ex == 0 && ey == 0)) continue;
            if (spans_cross(px, px + pw - 1, ex, ex + ew - 1) &&
                spans_cross(py, py + ph - 1, ey, ey + eh - 1)) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Walk the grid; returns blocked positions tried, or cap + 1 if it gave up early
    function automatic int find_free_slot(input logic [15:0] nw, input logic [15:0] nh,
                                          input int cap, output slot_result_t res);
        longint gw, gh, x0, x, y, w, h;
        int     steps;
        gw    = (grid_step_x == 0) ? 1 : grid_step_x;
        gh    = (grid_step_y == 0) ? 1 : grid_step_y;
        w     = nw;
        h     = nh;
        x0    = (w > gw) ? longint'(grid_margin) : grid_margin + (gw - w) / 2;
        x     = x0;
        y     = grid_margin;
        steps = 0;
        res   = '0;
        while (1) begin
            if (y > row_y_limit) begin
                res.status = STS_LIMIT;
                return steps;
            end
            if (!rect_blocks(x, y, w, h)) begin
                res.slot_x = (x > 65535) ? 16'hFFFF : 16'(x);
                res.slot_y = 16'(y);
                res.status = STS_FOUND;
                return steps;
            end
            steps++;
            if (steps > cap) return steps;
            x += gw;
            if (x + w > row_wrap) begin
                x = x0;
                y += gh;
            end
        end
        return steps;
    endfunction

    // Apply one accepted beat to the table and queue its result, if any
    function automatic void predict_command(input logic [1:0] cmd,
                                            input logic [15:0] rx, input logic [15:0] ry,
                                            input logic [15:0] rw, input logic [15:0] rh,
                                            input bit mgd,
                                            input logic [15:0] nw, input logic [15:0] nh);
        slot_result_t res;
        case (cmd)
            CMD_CLEAR: begin
                placed_count = 0;
            end
            CMD_ADD: begin
                if (placed_count >= TABLE_DEPTH) begin
                    res        = '0;
                    res.status = STS_FULL;
                    pending_slots.push_back(res);
                end else begin
                    placed[placed_count] = '{x: rx, y: ry, w: rw, h: rh, managed: mgd};
                    placed_count++;
                end
            end
            CMD_QUERY: begin
                void'(find_free_slot(nw, nh, 32'h7FFF_FFFF, res));
                pending_slots.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one command beat; leaves tvalid high, the next caller lowers or reuses it
    task automatic send_beat(input logic [1:0] cmd,
                             input logic [15:0] rx, input logic [15:0] ry,
                             input logic [15:0] rw, input logic [15:0] rh,
                             input bit mgd,
                             input logic [15:0] nw, input logic [15:0] nh);
        int gap;
        gap = bubbles_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {7'd0, nh, nw, mgd, rh, rw, ry, rx};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_command(cmd, rx, ry, rw, rh, mgd, nw, nh);
    endtask

    // Unused fields carry random bits so the block must ignore them
    task automatic send_add(input logic [15:0] rx, input logic [15:0] ry,
                            input logic [15:0] rw, input logic [15:0] rh, input bit mgd);
        send_beat(CMD_ADD, rx, ry, rw, rh, mgd, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_query(input logic [15:0] nw, input logic [15:0] nh);
        send_beat(CMD_QUERY, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom), nw, nh);
    endtask

    task automatic send_plain(input logic [1:0] cmd);
        send_beat(cmd, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Drain results and let any clear or add finish before touching registers
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_slots.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [15:0] mrg, input logic [15:0] gw,
                            input logic [15:0] gh, input logic [15:0] wrap,
                            input logic [15:0] ylim);
        logic [15:0] vals [5];
        logic [2:0]  regs [5];
        wait_idle();
        vals = '{mrg, gw, gh, wrap, ylim};
        regs = '{REG_MARGIN, REG_STEP_X, REG_STEP_Y, REG_ROW_END, REG_Y_LIMIT};
        for (int i = 0; i < 5; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        grid_margin = mrg;
        grid_step_x = gw;
        grid_step_y = gh;
        row_wrap    = wrap;
        row_y_limit = ylim;
    endtask

    // Result sink: random ready runs, stalls mostly short, a few long, while backpressure is on
    initial begin
        int hold;
        hold = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (!backpressure_on) begin
                i_m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 3) != 0) begin
                i_m_axis_tready <= 1'b1;
                hold = $urandom_range(0, 6);
            end else begin
                i_m_axis_tready <= 1'b0;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                   : $urandom_range(0, 2);
            end
        end
    end

    // Compare each result beat with the oldest expected slot
    always @(posedge i_clk) begin
        slot_result_t due;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_slots.size() == 0) begin
                $display("%0t: unexpected result beat: x %0d y %0d status %0d", $time,
                         o_m_axis_tdata[15:0], o_m_axis_tdata[31:16], o_m_axis_tuser);
                mismatches++;
            end else begin
                due = pending_slots.pop_front();
                if (o_m_axis_tdata[15:0] !== due.slot_x) begin
                    $display("%0t: slot_x expected %0d, actual %0d", $time,
                             due.slot_x, o_m_axis_tdata[15:0]);
                    mismatches++;
                end
                if (o_m_axis_tdata[31:16] !== due.slot_y) begin
                    $display("%0t: slot_y expected %0d, actual %0d", $time,
                             due.slot_y, o_m_axis_tdata[31:16]);
                    mismatches++;
                end
                if (o_m_axis_tuser !== due.status) begin
                    $display("%0t: status expected %0d, actual %0d", $time,
                             due.status, o_m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // Queries against reset register values and an empty table
    task automatic test_default_grid();
        send_query(16'd10, 16'd10);
        send_query(16'd100, 16'd5);
        send_query(16'd64, 16'd64);
    endtask

    // Managed, unmanaged, origin and zero-size entries; field extremes; clear
    task automatic test_overlap_rules();
        send_add(16'd31, 16'd4, 16'd10, 16'd10, 1'b1);
        send_add(16'd95, 16'd4, 16'd10, 16'd10, 1'b0);
        send_add(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
        send_query(16'd10, 16'd10);
        send_add(16'd159, 16'd4, 16'd0, 16'd0, 1'b1);
        send_query(16'd10, 16'd10);
        send_add(16'd95, 16'd4, 16'd1, 16'd1, 1'b1);
        send_query(16'd10, 16'd10);
        send_query(16'd0, 16'd0);
        send_add(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_beat(CMD_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
        send_plain(CMD_CLEAR);
        send_query(16'd10, 16'd10);
    endtask

    // Y limit passed, wide x saturation, zero grid steps, tiny grid
    task automatic test_extreme_settings();
        set_grid(16'd100, 16'd64, 16'd64, 16'd640, 16'd50);
        send_query(16'd10, 16'd10);
        set_grid(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_query(16'd1, 16'd1);
        send_query(16'hFFFF, 16'hFFFF);
        set_grid(16'd1, 16'd0, 16'd0, 16'd4, 16'd3);
        send_add(16'd0, 16'd1, 16'd4, 16'd4, 1'b1);
        send_query(16'd1, 16'd1);
        set_grid(16'd0, 16'd1, 16'd1, 16'd1, 16'd0);
        send_query(16'd1, 16'd1);
    endtask

    function automatic int capped(longint v);
        return (v > 65535) ? 65535 : int'(v);
    endfunction

    // Query sized to the grid; swapped for a clear when the search would run long
    task automatic random_query();
        logic [15:0]  nw, nh;
        slot_result_t probe;
        int           r;
        bit           ok;
        ok = 1'b0;
        for (int tries = 0; tries < 6 && !ok; tries++) begin
            r = $urandom_range(0, 9);
            if (r < 8) begin
                nw = 16'($urandom_range(1, capped(2 * longint'(grid_step_x) + 1)));
                nh = 16'($urandom_range(1, capped(2 * longint'(grid_step_y) + 1)));
            end else if (r == 8) begin
                nw = 16'($urandom);
                nh = 16'($urandom);
            end else begin
                nw = 16'($urandom_range(0, 2));
                nh = 16'($urandom_range(0, 2));
            end
            if (find_free_slot(nw, nh, STEP_CAP, probe) <= STEP_CAP) ok = 1'b1;
        end
        if (ok) send_query(nw, nh);
        else send_plain(CMD_CLEAR);
    endtask

    task automatic random_add();
        logic [15:0] rx, ry, rw, rh;
        if ($urandom_range(0, 99) < 85) begin
            rx = 16'($urandom_range(0, row_wrap));
            ry = 16'($urandom_range(grid_margin,
                                    capped(longint'(row_y_limit) + grid_step_y)));
            rw = 16'($urandom_range(0, capped(2 * longint'(grid_step_x))));
            rh = 16'($urandom_range(0, capped(2 * longint'(grid_step_y))));
            send_add(rx, ry, rw, rh, $urandom_range(0, 99) < 85);
        end else begin
            send_add(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     1'($urandom));
        end
    endtask

    // Pick a grid for one phase: mostly moderate, sometimes at the edges
    task automatic random_grid();
        logic [15:0] mrg, gw, gh;
        case ($urandom_range(0, 7))
            0: set_grid(16'd0, 16'd1, 16'd1, 16'd16, 16'd8);
            1: set_grid(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: set_grid(16'd0, 16'd0, 16'd0, 16'd32, 16'd16);
            default: begin
                mrg = 16'($urandom_range(0, 64));
                gw  = 16'($urandom_range(4, 128));
                gh  = 16'($urandom_range(4, 128));
                set_grid(mrg, gw, gh,
                         16'(capped(longint'(gw) * $urandom_range(1, 12) + mrg)),
                         16'(capped(longint'(gh) * $urandom_range(0, 6) + mrg)));
            end
        endcase
    endtask

    // Phases of random traffic; add-heavy phases fill the table past its depth
    task automatic test_random_traffic();
        int add_weight, r, sent;
        for (int phase = 0; phase < PHASES; phase++) begin
            random_grid();
            bubbles_on      = (phase % 4) != 1;
            backpressure_on = (phase % 4) != 2;
            add_weight      = (phase % 3 == 2) ? 80 : $urandom_range(35, 60);
            if ($urandom_range(0, 1) == 0) send_plain(CMD_CLEAR);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    send_plain(CMD_CLEAR);
                    sent++;
                end else if (r < 6) begin
                    send_plain(CMD_NOP);
                end else if (r < add_weight) begin
                    random_add();
                    sent++;
                end else begin
                    random_query();
                    sent++;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- main

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= CMD_NOP;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= REG_MARGIN;
        i_cfg_data      <= '0;
        mismatches      = 0;
        placed_count    = 0;
        grid_margin     = 16'd4;
        grid_step_x     = 16'd64;
        grid_step_y     = 16'd64;
        row_wrap        = 16'd640;
        row_y_limit     = 16'hFFFF;
        bubbles_on      = 1'b1;
        backpressure_on = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_grid();
        test_overlap_rules();
        test_extreme_settings();
        test_random_traffic();

        wait_idle();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
